// File: hdl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared widths, constants and control types of the atmospheric light
// estimator.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int LEVELS       = 256;
  localparam int LVL_W        = 8;
  localparam int CH_W         = 8;
  localparam int CHAN_W       = 10;
  localparam int CNT_W        = 22;
  localparam int SUM_W        = 31;
  localparam int MAX_PIXELS   = 2097152;
  localparam int PROD_W       = 32;
  localparam int SCALE        = 1000;
  localparam int PERMILLE_W   = 10;
  localparam int PERMILLE_RST = 999;
  localparam int LIGHT_W      = 16;
  localparam int DIV_W        = 24;
  localparam int IN_W         = 32;
  localparam int OUT_W        = 48;

  typedef struct packed {
    logic accept;
    logic walk_init;
    logic load_limit;
    logic walk_issue;
    logic walk_eval;
    logic div_start;
    logic emit;
  } ale_cmd_t;

  typedef struct packed {
    logic last_fire;
    logic walk_hit;
    logic walk_end;
    logic div_busy;
    logic out_busy;
  } ale_stat_t;

endpackage

// File: hdl/ale_divider.sv
// ----------------------------------------------------------------------------
// ale_divider
// Restoring divider, one quotient bit per cycle, for the 8.8 mean value.
// ----------------------------------------------------------------------------
module ale_divider import ale_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   sum_in,
  input  logic [DIV_W-1:0]   divisor,
  output logic               busy,
  output logic [LIGHT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(LIGHT_W + 1);

  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [LIGHT_W-1:0] low_r;
  logic [LIGHT_W-1:0] q_r;
  logic [DIV_W-1:0]   div_r;
  logic [STEP_W-1:0]  step_r;
  logic [DIV_W:0]     trial;
  logic               take;

  assign trial    = {rem_r, low_r[LIGHT_W-1]};
  assign take     = trial >= {1'b0, div_r};
  assign rem_nxt  = take ? DIV_W'(trial - {1'b0, div_r}) : DIV_W'(trial);
  assign busy     = step_r != '0;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(LIGHT_W);
    end else if (busy) begin
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DIV_W'(sum_in[SUM_W-1:8]);
      low_r <= {sum_in[7:0], 8'h00};
      q_r   <= '0;
      div_r <= divisor;
    end else if (busy) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[LIGHT_W-2:0], 1'b0};
      q_r   <= {q_r[LIGHT_W-2:0], take};
    end
  end

endmodule

// File: hdl/ale_datapath.sv
// ----------------------------------------------------------------------------
// ale_datapath
// Histogram memories, per-frame totals, bin walk, divider and output register.
// ----------------------------------------------------------------------------
module ale_datapath import ale_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ale_cmd_t              cmd,
  output ale_stat_t             stat,
  input  logic                  in_tvalid,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [PERMILLE_W-1:0] cfg_wr_data
);

  logic [CNT_W-1:0] cnt_mem [LEVELS];
  logic [SUM_W-1:0] sum_mem [LEVELS];
  logic [LEVELS-1:0] vbit_r;

  logic                  fire;
  logic                  count_en;
  logic [LVL_W-1:0]      rd_addr;
  logic [CHAN_W-1:0]     chan;
  logic [PERMILLE_W-1:0] frac_r;
  logic [CNT_W-1:0]      total_r;
  logic [SUM_W-1:0]      chan_total_r;

  logic                  acc_v_r;
  logic [LVL_W-1:0]      acc_lvl_r;
  logic [CHAN_W-1:0]     acc_chan_r;
  logic [CNT_W-1:0]      rd_cnt_r;
  logic [SUM_W-1:0]      rd_sum_r;
  logic                  rd_vld_r;
  logic                  byp_v_r;
  logic [LVL_W-1:0]      byp_lvl_r;
  logic [CNT_W-1:0]      byp_cnt_r;
  logic [SUM_W-1:0]      byp_sum_r;
  logic [CNT_W-1:0]      mem_cnt, base_cnt, new_cnt;
  logic [SUM_W-1:0]      mem_sum, base_sum, new_sum;

  logic [LVL_W-1:0]      walk_addr_r;
  logic [LVL_W-1:0]      rd_idx_r;
  logic                  rd_live_r;
  logic [PROD_W-1:0]     limit_r;
  logic [CNT_W-1:0]      cum_r, cum_nxt, cum0_r;
  logic [SUM_W-1:0]      csum_r, csum_nxt, csum0_r;
  logic                  hit;
  logic                  at_end;
  logic [LVL_W-1:0]      thr_r;
  logic [CNT_W-1:0]      bcount_r;
  logic [SUM_W-1:0]      bsum_r;

  logic [LIGHT_W-1:0]    quotient;
  logic                  out_tvalid_r;
  logic [LIGHT_W-1:0]    out_light_r;
  logic [LVL_W-1:0]      out_thr_r;
  logic [CNT_W-1:0]      out_count_r;
  logic                  out_flag_r;

  assign fire     = in_tvalid && cmd.accept;
  assign count_en = total_r < CNT_W'(MAX_PIXELS);
  assign rd_addr  = cmd.walk_issue ? walk_addr_r : in_tdata[LVL_W-1:0];
  assign chan     = CHAN_W'(in_tdata[15:8]) + CHAN_W'(in_tdata[23:16])
                  + CHAN_W'(in_tdata[31:24]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= PERMILLE_W'(PERMILLE_RST);
    end else if (cfg_wr_en) begin
      frac_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_v_r) begin
      cnt_mem[acc_lvl_r] <= new_cnt;
      sum_mem[acc_lvl_r] <= new_sum;
    end
    rd_cnt_r <= cnt_mem[rd_addr];
    rd_sum_r <= sum_mem[rd_addr];
  end

  assign mem_cnt  = rd_vld_r ? rd_cnt_r : '0;
  assign mem_sum  = rd_vld_r ? rd_sum_r : '0;
  assign base_cnt = (byp_v_r && byp_lvl_r == acc_lvl_r) ? byp_cnt_r : mem_cnt;
  assign base_sum = (byp_v_r && byp_lvl_r == acc_lvl_r) ? byp_sum_r : mem_sum;
  assign new_cnt  = base_cnt + CNT_W'(1);
  assign new_sum  = base_sum + SUM_W'(acc_chan_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbit_r       <= '0;
      acc_v_r      <= 1'b0;
      byp_v_r      <= 1'b0;
      total_r      <= '0;
      chan_total_r <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      rd_vld_r <= vbit_r[rd_addr];
      acc_v_r  <= fire && count_en;
      byp_v_r  <= acc_v_r;
      if (cmd.emit) begin
        vbit_r       <= '0;
        total_r      <= '0;
        chan_total_r <= '0;
      end else begin
        if (acc_v_r) begin
          vbit_r[acc_lvl_r] <= 1'b1;
        end
        if (fire && count_en) begin
          total_r      <= total_r + CNT_W'(1);
          chan_total_r <= chan_total_r + SUM_W'(chan);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_lvl_r  <= in_tdata[LVL_W-1:0];
    acc_chan_r <= chan;
    byp_lvl_r  <= acc_lvl_r;
    byp_cnt_r  <= new_cnt;
    byp_sum_r  <= new_sum;
  end

  assign cum_nxt  = cum_r + mem_cnt;
  assign csum_nxt = csum_r + mem_sum;
  assign hit      = (PROD_W'(cum_nxt) * PROD_W'(SCALE)) > limit_r;
  assign at_end   = rd_idx_r == LVL_W'(LEVELS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_live_r <= 1'b0;
    end else begin
      rd_live_r <= cmd.walk_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_addr_r <= '0;
      cum_r       <= '0;
      csum_r      <= '0;
    end else if (cmd.walk_issue) begin
      walk_addr_r <= walk_addr_r + LVL_W'(1);
    end
    rd_idx_r <= walk_addr_r;
    if (cmd.load_limit) begin
      limit_r <= PROD_W'(frac_r) * PROD_W'(total_r);
    end
    if (cmd.walk_eval && rd_live_r) begin
      cum_r  <= cum_nxt;
      csum_r <= csum_nxt;
      if (rd_idx_r == '0) begin
        cum0_r  <= cum_nxt;
        csum0_r <= csum_nxt;
      end
      if (hit) begin
        thr_r    <= rd_idx_r;
        bcount_r <= total_r - cum_nxt;
        bsum_r   <= chan_total_r - csum_nxt;
      end else if (at_end) begin
        thr_r    <= '0;
        bcount_r <= total_r - cum0_r;
        bsum_r   <= chan_total_r - csum0_r;
      end
    end
  end

  ale_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .sum_in   (bsum_r),
    .divisor  (DIV_W'(bcount_r) + DIV_W'({bcount_r, 1'b0})),
    .busy     (stat.div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_light_r <= (bcount_r == '0) ? '0 : quotient;
      out_thr_r   <= thr_r;
      out_count_r <= bcount_r;
      out_flag_r  <= bcount_r == '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_count_r, out_thr_r, out_light_r};
  assign out_tuser  = out_flag_r;

  assign stat.last_fire = fire && in_tlast;
  assign stat.walk_hit  = rd_live_r && hit;
  assign stat.walk_end  = rd_live_r && at_end;
  assign stat.out_busy  = out_tvalid_r && !out_tready;

endmodule

// File: hdl/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl
// Frame sequencer: accumulate, drain, bin walk, divide and emit.
// ----------------------------------------------------------------------------
module ale_ctrl import ale_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ale_stat_t stat,
  output ale_cmd_t  cmd
);

  localparam logic [2:0] S_RUN      = 3'd0;
  localparam logic [2:0] S_DRAIN    = 3'd1;
  localparam logic [2:0] S_LIMIT    = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_DIVSTART = 3'd4;
  localparam logic [2:0] S_DIVWAIT  = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_RUN: begin
        cmd.accept = 1'b1;
        if (stat.last_fire) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_LIMIT;
      end
      S_LIMIT: begin
        cmd.load_limit = 1'b1;
        cmd.walk_issue = 1'b1;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        cmd.walk_issue = 1'b1;
        cmd.walk_eval  = 1'b1;
        if (stat.walk_hit || stat.walk_end) begin
          state_nxt = S_DIVSTART;
        end
      end
      S_DIVSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

endmodule

// File: hdl/atmospheric_light_estimator.sv
// ----------------------------------------------------------------------------
// atmospheric_light_estimator
// Dark-channel atmospheric light estimate over one frame of pixels.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock while the block accumulates a frame. After
// the transfer that carries tlast, input is held off while the block drains,
// walks up to the 256 histogram bins through the memory read port and then
// runs a bit-serial divider; the result is emitted after that, once any
// previous result has been taken.
// The result leaves through an output register, so the next frame may start
// while it waits. The store is cleared when the result is emitted.
module atmospheric_light_estimator import ale_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // dark_level, blue_value, green_value, red_value
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // light_level_q8, threshold_level, bright_count, two zero bits
  output logic [OUT_W-1:0]      out_tdata,
  // no_bright_pixels
  output logic                  out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [PERMILLE_W-1:0] cfg_wr_data
);

  ale_cmd_t  cmd;
  ale_stat_t stat;

  assign in_tready = cmd.accept;

  ale_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  ale_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tvalid   (in_tvalid),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

// File: dv/atmospheric_light_estimator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atmospheric_light_estimator_test
// Self-checking testbench for the atmospheric light estimator.
// ----------------------------------------------------------------------------
// Pixel frames go into the block over its input stream. A scoreboard keeps its
// own dark-level histogram and per-level channel sums. On each frame's last
// pixel it walks the levels to find the threshold. It then works out the
// light estimate and checks it against the result that the block emits. A
// short directed part comes first. It covers the field extremes, a setting of
// zero, and settings at or above 1000, where the fraction is never exceeded.
// It also covers frames with no bright pixel. Random frames of random length
// and level spread follow. Both stream sides idle at random, and the fraction
// setting changes between phases.
// ----------------------------------------------------------------------------
module atmospheric_light_estimator_test;
  import ale_pkg::*;

  localparam int THR_LSB       = LIGHT_W;
  localparam int CNT_LSB       = LIGHT_W + LVL_W;
  localparam int PAD_LSB       = LIGHT_W + LVL_W + CNT_W;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 850;
  localparam int RANDOM_FRAMES = 40;

  typedef struct packed {
    logic [LVL_W-1:0] dark;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic             last;
  } pixel_t;

  typedef struct packed {
    logic [LIGHT_W-1:0] light_level_q8;
    logic [LVL_W-1:0]   threshold_level;
    logic [CNT_W-1:0]   bright_count;
    logic               no_bright_pixels;
  } airlight_t;

  class airlight_scoreboard;
    logic [CNT_W-1:0]      bin_pixels [LEVELS];
    logic [SUM_W-1:0]      bin_sums [LEVELS];
    logic [CNT_W-1:0]      frame_pixels;
    logic [PERMILLE_W-1:0] fraction;
    airlight_t             expected_lights [$];
    int                    errors;

    function new();
      fraction = PERMILLE_W'(PERMILLE_RST);
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (bin_pixels[i]) begin
        bin_pixels[i] = '0;
        bin_sums[i] = '0;
      end
      frame_pixels = '0;
    endfunction

    function void set_fraction(logic [PERMILLE_W-1:0] value);
      fraction = value;
    endfunction

    function int pending();
      return expected_lights.size();
    endfunction

    function void note_pixel(pixel_t px);
      logic [CHAN_W-1:0] chan;
      logic [63:0]       limit;
      logic [63:0]       cum;
      logic [63:0]       bright;
      logic [63:0]       bright_sum;
      int                thr;
      airlight_t         light;
      chan = {2'b00, px.blue} + {2'b00, px.green} + {2'b00, px.red};
      // A frame longer than the store allows keeps only its first pixels.
      if (frame_pixels < MAX_PIXELS) begin
        bin_pixels[px.dark] += 1'b1;
        bin_sums[px.dark] += chan;
        frame_pixels += 1'b1;
      end
      if (!px.last) return;
      limit = 64'(fraction) * 64'(frame_pixels);
      cum = '0;
      thr = 0;
      for (int i = 0; i < LEVELS; i++) begin
        cum += bin_pixels[i];
        if (cum * SCALE > limit) begin
          thr = i;
          break;
        end
      end
      bright = '0;
      bright_sum = '0;
      for (int i = thr + 1; i < LEVELS; i++) begin
        bright += bin_pixels[i];
        bright_sum += bin_sums[i];
      end
      light.threshold_level = LVL_W'(thr);
      light.bright_count = bright[CNT_W-1:0];
      light.no_bright_pixels = (bright == 0);
      light.light_level_q8 = (bright == 0) ? '0 :
                             LIGHT_W'((bright_sum * 256) / (3 * bright));
      expected_lights.push_back(light);
      clear_frame();
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_light(logic [OUT_W-1:0] data, logic flag);
      airlight_t want;
      if (expected_lights.size() == 0) begin
        report($sformatf("result %h/%b with none expected", data, flag));
        return;
      end
      want = expected_lights.pop_front();
      if (data[LIGHT_W-1:0] !== want.light_level_q8)
        report($sformatf("light_level_q8 %0d, expected %0d",
                         data[LIGHT_W-1:0], want.light_level_q8));
      if (data[CNT_LSB-1:THR_LSB] !== want.threshold_level)
        report($sformatf("threshold_level %0d, expected %0d",
                         data[CNT_LSB-1:THR_LSB], want.threshold_level));
      if (data[PAD_LSB-1:CNT_LSB] !== want.bright_count)
        report($sformatf("bright_count %0d, expected %0d",
                         data[PAD_LSB-1:CNT_LSB], want.bright_count));
      if (data[OUT_W-1:PAD_LSB] !== '0)
        report($sformatf("padding bits %b, expected zero", data[OUT_W-1:PAD_LSB]));
      if (flag !== want.no_bright_pixels)
        report($sformatf("no_bright_pixels %b, expected %b", flag, want.no_bright_pixels));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en;
  logic [PERMILLE_W-1:0] cfg_wr_data;

  airlight_scoreboard sb;
  int in_gap_max;
  int out_stall_max;
  int cycles = 0;

  atmospheric_light_estimator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {px.red, px.green, px.blue, px.dark};
    in_tlast <= px.last;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fraction(input logic [PERMILLE_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_fraction(value);
  endtask

  // Style 0 spreads dark levels over the full range, style 1 packs them
  // near a base level, and style 2 keeps them at the ends of the range.
  function automatic pixel_t random_pixel(int style, logic [LVL_W-1:0] base, bit last);
    pixel_t           px;
    logic [LVL_W-1:0] offset;
    offset = LVL_W'($urandom_range(0, 7));
    case (style)
      0: px.dark = LVL_W'($urandom);
      1: px.dark = (base > 8'd247) ? base - offset : base + offset;
      default: begin
        case ($urandom_range(0, 3))
          0: px.dark = 8'd0;
          1: px.dark = 8'd1;
          2: px.dark = 8'd254;
          default: px.dark = 8'd255;
        endcase
      end
    endcase
    case ($urandom_range(0, 7))
      0: {px.blue, px.green, px.red} = '0;
      1: {px.blue, px.green, px.red} = '1;
      default: {px.blue, px.green, px.red} = 24'($urandom);
    endcase
    px.last = last;
    return px;
  endfunction

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_light(out_tdata, out_tuser);
    end
  end

  initial begin : stimulus
    int                    frames;
    int                    items;
    int                    len;
    int                    style;
    logic [LVL_W-1:0]      base;
    logic [PERMILLE_W-1:0] fraction;
    sb = new();
    in_gap_max = 0;
    out_stall_max = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-pixel frames under the reset setting leave no bright pixel.
    send_pixel(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
    send_pixel(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
    settle();
    write_fraction(10'd0);
    send_pixel(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
    send_pixel(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0});
    send_pixel(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0});
    send_pixel(pixel_t'{8'd1, 8'd255, 8'd0, 8'd128, 1'b0});
    send_pixel(pixel_t'{8'd254, 8'd1, 8'd2, 8'd3, 1'b1});
    settle();
    write_fraction(10'd1023);
    send_pixel(pixel_t'{8'd0, 8'd17, 8'd34, 8'd51, 1'b0});
    send_pixel(pixel_t'{8'd200, 8'd255, 8'd0, 8'd255, 1'b0});
    send_pixel(pixel_t'{8'd255, 8'd10, 8'd20, 8'd30, 1'b1});
    settle();
    write_fraction(10'd1000);
    send_pixel(pixel_t'{8'd128, 8'd200, 8'd100, 8'd50, 1'b0});
    send_pixel(pixel_t'{8'd128, 8'd1, 8'd1, 8'd1, 1'b0});
    send_pixel(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
    settle();
    in_gap_max = 3;
    out_stall_max = 3;
    write_fraction(10'd500);
    send_pixel(pixel_t'{8'd10, 8'd100, 8'd110, 8'd120, 1'b0});
    send_pixel(pixel_t'{8'd20, 8'd90, 8'd80, 8'd70, 1'b0});
    send_pixel(pixel_t'{8'd30, 8'd255, 8'd255, 8'd0, 1'b0});
    send_pixel(pixel_t'{8'd40, 8'd5, 8'd6, 8'd7, 1'b0});
    send_pixel(pixel_t'{8'd50, 8'd250, 8'd251, 8'd252, 1'b0});
    send_pixel(pixel_t'{8'd60, 8'd33, 8'd66, 8'd99, 1'b1});

    frames = 0;
    items = 0;
    while (items < RANDOM_ITEMS || frames < RANDOM_FRAMES) begin
      settle();
      case ($urandom_range(0, 7))
        0: fraction = 10'd0;
        1: fraction = 10'd1;
        2: fraction = 10'd999;
        3: fraction = 10'd1000;
        4: fraction = 10'd1023;
        default: fraction = PERMILLE_W'($urandom_range(0, 1023));
      endcase
      write_fraction(fraction);
      in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      repeat ($urandom_range(2, 6)) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        style = $urandom_range(0, 2);
        base = LVL_W'($urandom);
        for (int n = 1; n <= len; n++) send_pixel(random_pixel(style, base, n == len));
        items += len;
        frames++;
      end
    end
    settle();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
